// ===== hdl/spq_pkg.sv =====
// Shared types for the stable sorted priority queue.
`timescale 1ns / 1ps

package spq_pkg;

	// Operation code carried by each request transaction
	typedef enum logic {
		OP_INSERT  = 1'b0,
		OP_EXTRACT = 1'b1
	} op_t;

	// Per-cycle command broadcast to every cell of the chain
	typedef struct packed {
		logic do_insert;
		logic do_extract;
	} cell_ctrl_t;

endpackage

// ===== hdl/stable_priority_queue_unit.sv =====
// Top level of the stable sorted priority queue built as a chain of cells.
// Usage:
//   Request channel (req_valid / req_stall) carries op, key and tag. op selects
//   insert or extract of the smallest key. Every request yields exactly one
//   response transaction on (rsp_valid / rsp_stall) with out_valid, out_key,
//   out_tag, is_empty, overflow and occupancy after the operation.
//   Equal keys leave in arrival order. Insert into a full queue is dropped and
//   flagged by overflow; extract from an empty queue returns out_valid low.
//   The response is registered and appears in the cycle after the request is taken.
//   Throughput: one request per cycle while req_stall is low; every cell compares
//   its key with the incoming key and shifts in the same cycle, so the chain
//   has finished each operation by the time the next request is taken.
//   When the receiver stalls, the response register holds and req_stall rises
//   until the response is taken; a request is taken in the same cycle that
//   the waiting response leaves.
//   Reset (arst_n low) empties the queue and clears the response valid flag;
//   slot contents are not cleared and are never read before being written.
`timescale 1ns / 1ps

module stable_priority_queue_unit #(
	parameter int QUEUE_DEPTH = 16,
	parameter int KEY_BITS    = 16,
	parameter int TAG_BITS    = 32,
	localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  logic                op,
	input  logic [KEY_BITS-1:0] key,
	input  logic [TAG_BITS-1:0] tag,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output logic                out_valid,
	output logic [KEY_BITS-1:0] out_key,
	output logic [TAG_BITS-1:0] out_tag,
	output logic                is_empty,
	output logic                overflow,
	output logic [CNT_W-1:0]    occupancy
);
	import spq_pkg::*;

	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

	logic [CNT_W-1:0]    count_q;
	logic                rsp_valid_q;
	logic                accept;
	logic                full;
	logic                empty;
	cell_ctrl_t          ctrl;
	logic [CNT_W-1:0]    count_next;

	logic                cell_le  [QUEUE_DEPTH];
	logic [KEY_BITS-1:0] cell_key [QUEUE_DEPTH];
	logic [TAG_BITS-1:0] cell_tag [QUEUE_DEPTH];

	// Request handshake: stall only while a response waits on a stalled receiver
	assign req_stall = rsp_valid_q && rsp_stall;
	assign accept    = req_valid && !req_stall;
	assign full      = (count_q == DEPTH_CNT);
	assign empty     = (count_q == '0);

	// Command for the chain
	always_comb begin
		ctrl.do_insert  = accept && (op_t'(op) == OP_INSERT) && !full;
		ctrl.do_extract = accept && (op_t'(op) == OP_EXTRACT) && !empty;
	end

	always_comb begin
		count_next = count_q;
		if (ctrl.do_insert) begin
			count_next = count_q + CNT_W'(1);
		end else if (ctrl.do_extract) begin
			count_next = count_q - CNT_W'(1);
		end
	end

	// Chain of cells
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic                occ;
		logic                lft_le;
		logic [KEY_BITS-1:0] lft_key;
		logic [TAG_BITS-1:0] lft_tag;
		logic [KEY_BITS-1:0] rgt_key;
		logic [TAG_BITS-1:0] rgt_tag;

		assign occ = (CNT_W'(i) < count_q);

		if (i == 0) begin : g_head
			assign lft_le  = 1'b1;
			assign lft_key = '0;
			assign lft_tag = '0;
		end else begin : g_body
			assign lft_le  = cell_le[i-1];
			assign lft_key = cell_key[i-1];
			assign lft_tag = cell_tag[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign rgt_key = '0;
			assign rgt_tag = '0;
		end else begin : g_inner
			assign rgt_key = cell_key[i+1];
			assign rgt_tag = cell_tag[i+1];
		end

		spq_cell #(
			.KEY_BITS(KEY_BITS),
			.TAG_BITS(TAG_BITS)
		) u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.occupied (occ),
			.new_key  (key),
			.new_tag  (tag),
			.left_le  (lft_le),
			.left_key (lft_key),
			.left_tag (lft_tag),
			.right_key(rgt_key),
			.right_tag(rgt_tag),
			.le       (cell_le[i]),
			.key      (cell_key[i]),
			.tag      (cell_tag[i])
		);
	end

	// Occupancy and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_next;
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Response payload
	always_ff @(posedge clk) begin
		if (accept) begin
			out_valid <= ctrl.do_extract;
			out_key   <= ctrl.do_extract ? cell_key[0] : '0;
			out_tag   <= ctrl.do_extract ? cell_tag[0] : '0;
			is_empty  <= (count_next == '0);
			overflow  <= (op_t'(op) == OP_INSERT) && full;
			occupancy <= count_next;
		end
	end

	assign rsp_valid = rsp_valid_q;

`ifndef SYNTHESIS
	// Occupancy never passes the depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_CNT)
		else $error("queue occupancy above depth");

	// Extract from a non-empty queue returns an entry next cycle
	a_extract_hit: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.do_extract |=> (rsp_valid && out_valid && !overflow))
		else $error("extract did not return an entry");

	// Empty flag agrees with occupancy
	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (is_empty == (occupancy == '0)))
		else $error("empty flag disagrees with occupancy");

	// Head of the chain stays sorted
	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= CNT_W'(2)) |-> (cell_key[0] <= cell_key[1]))
		else $error("head cells out of order");
`endif

endmodule

// ===== hdl/spq_cell.sv =====
// One slot of the sorted chain: holds a key and tag, shifts left or right.
`timescale 1ns / 1ps

module spq_cell #(
	parameter int KEY_BITS = 16,
	parameter int TAG_BITS = 32
) (
	input  logic                clk,
	input  spq_pkg::cell_ctrl_t ctrl,
	input  logic                occupied,
	input  logic [KEY_BITS-1:0] new_key,
	input  logic [TAG_BITS-1:0] new_tag,
	input  logic                left_le,
	input  logic [KEY_BITS-1:0] left_key,
	input  logic [TAG_BITS-1:0] left_tag,
	input  logic [KEY_BITS-1:0] right_key,
	input  logic [TAG_BITS-1:0] right_tag,
	output logic                le,
	output logic [KEY_BITS-1:0] key,
	output logic [TAG_BITS-1:0] tag
);
	import spq_pkg::*;

	logic [KEY_BITS-1:0] key_q;
	logic [TAG_BITS-1:0] tag_q;

	// Entry stays ahead of the new key (equal keys keep arrival order)
	assign le  = occupied && (key_q <= new_key);
	assign key = key_q;
	assign tag = tag_q;

	// Insert: keep, take the new entry, or take the left neighbor.
	// Extract: take the right neighbor.
	always_ff @(posedge clk) begin
		if (ctrl.do_insert) begin
			if (!le) begin
				if (left_le) begin
					key_q <= new_key;
					tag_q <= new_tag;
				end else begin
					key_q <= left_key;
					tag_q <= left_tag;
				end
			end
		end else if (ctrl.do_extract) begin
			key_q <= right_key;
			tag_q <= right_tag;
		end
	end

endmodule

// ===== sim/stable_priority_queue_unit_tb.sv =====
// Self-checking testbench for the stable priority queue: directed table, then random traffic.
`timescale 1ns / 1ps

module stable_priority_queue_unit_tb;
	import spq_pkg::*;

	localparam int DEPTH       = 16;
	localparam int N_RAND      = 530;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;

	// One response transaction, as the block reports it
	typedef struct packed {
		logic        vld;
		logic [15:0] k;
		logic [31:0] t;
		logic        emp;
		logic        ovf;
		logic [4:0]  occ;
	} rsp_t;

	// Directed row: the response is typed in only where it is obvious
	typedef struct packed {
		op_t         o;
		logic [15:0] k;
		logic [31:0] t;
		logic        pinned;
		rsp_t        want;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	op_t         req_op = OP_INSERT;
	logic [15:0] req_key = '0;
	logic [31:0] req_tag = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	logic        out_valid;
	logic [15:0] out_key;
	logic [31:0] out_tag;
	logic        is_empty;
	logic        overflow;
	logic [4:0]  occupancy;

	stable_priority_queue_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.op        (req_op),
		.key       (req_key),
		.tag       (req_tag),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.out_valid (out_valid),
		.out_key   (out_key),
		.out_tag   (out_tag),
		.is_empty  (is_empty),
		.overflow  (overflow),
		.occupancy (occupancy)
	);

	always #1 clk = ~clk;

	// Sorted mirror of the queue contents
	logic [15:0] sorted_keys [DEPTH];
	logic [31:0] sorted_tags [DEPTH];
	int          sorted_cnt = 0;

	rsp_t pending_rsp [$];
	int   err_cnt = 0;
	int   n_checked = 0;
	int   n_insert = 0, n_extract = 0, n_dropped = 0, n_dry_extract = 0, peak_occ = 0;
	int   cycle_cnt = 0;
	int   hold_req = 0;

	stim_row_t dir_tbl [24] = '{
		// extract from empty queue
		'{OP_EXTRACT, 16'h1234, 32'h8765_4321, 1'b1, '{1'b0, 16'h0, 32'h0, 1'b1, 1'b0, 5'd0}},
		// key and tag extremes in, then out in key order
		'{OP_INSERT,  16'hFFFF, 32'hFFFF_FFFF, 1'b1, '{1'b0, 16'h0, 32'h0, 1'b0, 1'b0, 5'd1}},
		'{OP_INSERT,  16'h0000, 32'h0000_0000, 1'b1, '{1'b0, 16'h0, 32'h0, 1'b0, 1'b0, 5'd2}},
		'{OP_EXTRACT, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, '{1'b1, 16'h0, 32'h0, 1'b0, 1'b0, 5'd1}},
		'{OP_EXTRACT, 16'h0000, 32'h0000_0000, 1'b1,
			'{1'b1, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 5'd0}},
		'{OP_EXTRACT, 16'h5555, 32'hAAAA_AAAA, 1'b1, '{1'b0, 16'h0, 32'h0, 1'b1, 1'b0, 5'd0}},
		// fill to the top with repeated keys so arrival order matters
		'{OP_INSERT,  16'h0007, 32'hA5A5_0000, 1'b0, '0},
		'{OP_INSERT,  16'h0003, 32'hA5A5_0001, 1'b0, '0},
		'{OP_INSERT,  16'h0007, 32'hA5A5_0002, 1'b0, '0},
		'{OP_INSERT,  16'hFFFF, 32'hA5A5_0003, 1'b0, '0},
		'{OP_INSERT,  16'h0003, 32'hA5A5_0004, 1'b0, '0},
		'{OP_INSERT,  16'h0000, 32'hA5A5_0005, 1'b0, '0},
		'{OP_INSERT,  16'h0007, 32'hA5A5_0006, 1'b0, '0},
		'{OP_INSERT,  16'h8000, 32'h5A5A_0007, 1'b0, '0},
		'{OP_INSERT,  16'h0003, 32'h5A5A_0008, 1'b0, '0},
		'{OP_INSERT,  16'h0007, 32'h5A5A_0009, 1'b0, '0},
		'{OP_INSERT,  16'h00FF, 32'h5A5A_000A, 1'b0, '0},
		'{OP_INSERT,  16'h0000, 32'h5A5A_000B, 1'b0, '0},
		'{OP_INSERT,  16'hFFFF, 32'h0F0F_000C, 1'b0, '0},
		'{OP_INSERT,  16'h0007, 32'h0F0F_000D, 1'b0, '0},
		'{OP_INSERT,  16'h0001, 32'hF0F0_000E, 1'b0, '0},
		'{OP_INSERT,  16'h0003, 32'hF0F0_000F, 1'b0, '0},
		// insert into a full queue is dropped
		'{OP_INSERT,  16'h0002, 32'hDEAD_BEEF, 1'b1, '{1'b0, 16'h0, 32'h0, 1'b0, 1'b1, 5'd16}},
		'{OP_INSERT,  16'hFFFF, 32'h0000_0000, 1'b1, '{1'b0, 16'h0, 32'h0, 1'b0, 1'b1, 5'd16}}
	};

	// Apply one operation to the mirror and return the response it should cause
	function automatic rsp_t queue_apply(input op_t o, input logic [15:0] k, input logic [31:0] t);
		rsp_t r;
		int   pos;
		r = '0;
		if (o == OP_INSERT) begin
			n_insert++;
			if (sorted_cnt >= DEPTH) begin
				r.ovf = 1'b1;
				n_dropped++;
			end else begin
				pos = 0;
				while (pos < sorted_cnt && sorted_keys[pos] <= k)
					pos++;
				for (int i = sorted_cnt; i > pos; i--) begin
					sorted_keys[i] = sorted_keys[i-1];
					sorted_tags[i] = sorted_tags[i-1];
				end
				sorted_keys[pos] = k;
				sorted_tags[pos] = t;
				sorted_cnt++;
			end
		end else begin
			n_extract++;
			if (sorted_cnt > 0) begin
				r.vld = 1'b1;
				r.k   = sorted_keys[0];
				r.t   = sorted_tags[0];
				for (int i = 1; i < sorted_cnt; i++) begin
					sorted_keys[i-1] = sorted_keys[i];
					sorted_tags[i-1] = sorted_tags[i];
				end
				sorted_cnt--;
			end else begin
				n_dry_extract++;
			end
		end
		if (sorted_cnt > peak_occ)
			peak_occ = sorted_cnt;
		r.emp = (sorted_cnt == 0);
		r.occ = sorted_cnt[4:0];
		return r;
	endfunction

	// Offer one request transaction and log what it should produce once taken
	task automatic send_req(input op_t o, input logic [15:0] k, input logic [31:0] t,
			input logic pinned, input rsp_t pin_val);
		rsp_t e;
		req_valid <= 1'b1;
		req_op    <= o;
		req_key   <= k;
		req_tag   <= t;
		do
			@(posedge clk);
		while (req_stall);
		e = queue_apply(o, k, t);
		if (pinned)
			e = pin_val;
		pending_rsp.push_back(e);
		@(negedge clk);
	endtask

	// Sender idle time: mostly none, sometimes short, rarely long
	task automatic sender_gap(input bit burst);
		int r, n;
		r = $urandom_range(0, 9);
		if (burst || r < 6)
			n = 0;
		else if (r < 9)
			n = $urandom_range(1, 3);
		else
			n = $urandom_range(5, 30);
		if (n > 0) begin
			req_valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	task automatic check_field(input string fname, input logic [31:0] want_v,
			input logic [31:0] got_v);
		if (want_v !== got_v) begin
			err_cnt++;
			$display("%0t ns: %s mismatch, expected %0h, got %0h", $time, fname, want_v, got_v);
		end
	endtask

	// Response checker: every taken response against the oldest expectation
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				err_cnt++;
				$display("%0t ns: response with nothing expected, key %0h tag %0h",
					$time, out_key, out_tag);
			end else begin
				want = pending_rsp.pop_front();
				n_checked++;
				check_field("out_valid", 32'(want.vld), 32'(out_valid));
				check_field("out_key",   32'(want.k),   32'(out_key));
				check_field("out_tag",   want.t,        out_tag);
				check_field("is_empty",  32'(want.emp), 32'(is_empty));
				check_field("overflow",  32'(want.ovf), 32'(overflow));
				check_field("occupancy", 32'(want.occ), 32'(occupancy));
			end
		end
	end

	// Run-away guard
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("%0t ns: timeout after %0d cycles, %0d responses outstanding",
				$time, cycle_cnt, pending_rsp.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	// Receiver: random stall bursts, plus one long hold-off on request
	initial begin
		int   r, n;
		logic s;
		forever begin
			if (hold_req > 0) begin
				n = hold_req;
				hold_req = 0;
				s = 1'b1;
			end else begin
				r = $urandom_range(0, 9);
				if (r < 5) begin
					s = 1'b0;
					n = $urandom_range(1, 20);
				end else if (r < 9) begin
					s = 1'b1;
					n = $urandom_range(1, 3);
				end else begin
					s = 1'b1;
					n = $urandom_range(10, 40);
				end
			end
			repeat (n) begin
				@(negedge clk);
				rsp_stall <= s;
			end
		end
	end

	// Stimulus
	initial begin
		int   sent, seg_len, bias, pick;
		bit   burst;
		op_t  o;
		logic [15:0] k;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table
		foreach (dir_tbl[i]) begin
			sender_gap(i < 12);
			send_req(dir_tbl[i].o, dir_tbl[i].k, dir_tbl[i].t, dir_tbl[i].pinned, dir_tbl[i].want);
		end

		// random segments, most leaning toward filling or draining the queue
		sent = 0;
		while (sent < N_RAND) begin
			seg_len = $urandom_range(8, 40);
			case ($urandom_range(0, 3))
				0: bias = 10;
				1: bias = 50;
				2: bias = 80;
				default: bias = 100;
			endcase
			burst = ($urandom_range(0, 3) == 0);
			for (int j = 0; j < seg_len && sent < N_RAND; j++) begin
				o = ($urandom_range(0, 99) < bias) ? OP_INSERT : OP_EXTRACT;
				pick = $urandom_range(0, 7);
				if (pick < 4)
					k = 16'($urandom_range(0, 7));
				else if (pick < 6)
					k = 16'($urandom);
				else if (pick == 6)
					k = 16'h0000;
				else
					k = 16'hFFFF;
				// long receiver hold-off while the sender keeps offering
				if (sent == 150)
					hold_req = HOLD_CYCLES;
				sender_gap(burst);
				send_req(o, k, $urandom, 1'b0, '0);
				sent++;
			end
		end

		// drain
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (5) @(posedge clk);

		$display("Ran %0d inserts (%0d dropped when full) and %0d extracts (%0d on empty).",
			n_insert, n_dropped, n_extract, n_dry_extract);
		$display("Checked %0d responses, peak occupancy %0d, %0d mismatches.",
			n_checked, peak_occ, err_cnt);
		if (err_cnt == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/stable_priority_queue_unit.sv
sim/stable_priority_queue_unit_tb.sv
